// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL top level of the sniffer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ffs_pkg.sv =====
// Package with codes, character constants and byte classifiers for the sniffer.
package ffs_pkg;

  localparam int unsigned PERMILLE_W = 10;
  localparam int unsigned CODE_W     = 3;
  localparam int unsigned REG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_DNA       = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PROTEIN   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FASTA_TXT = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_TEXT      = 2'd3;

  // Register reset values in permille
  localparam logic [PERMILLE_W-1:0] DNA_RESET       = 10'd700;
  localparam logic [PERMILLE_W-1:0] PROTEIN_RESET   = 10'd700;
  localparam logic [PERMILLE_W-1:0] FASTA_TXT_RESET = 10'd910;
  localparam logic [PERMILLE_W-1:0] TEXT_RESET      = 10'd800;
  localparam logic [PERMILLE_W-1:0] PERMILLE_SCALE  = 10'd1000;

  // Format codes
  localparam logic [CODE_W-1:0] FMT_UNKNOWN    = 3'd0;
  localparam logic [CODE_W-1:0] FMT_XML        = 3'd1;
  localparam logic [CODE_W-1:0] FMT_FASTA      = 3'd2;
  localparam logic [CODE_W-1:0] FMT_TEXT_ASN   = 3'd3;
  localparam logic [CODE_W-1:0] FMT_BINARY_ASN = 3'd4;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BRACE = 8'h7B;
  localparam int unsigned SIG_LEN = 5;

  typedef logic [7:0]            byte_t;
  typedef logic [CODE_W-1:0]     code_t;
  typedef logic [PERMILLE_W-1:0] permille_t;
  typedef logic [REG_IDX_W-1:0]  reg_idx_t;

  // Upper-case signature character at a position of the XML prefix
  function automatic byte_t xml_sig(input logic [2:0] pos);
    byte_t ch;
    case (pos)
      3'd0:    ch = 8'h3C;
      3'd1:    ch = 8'h3F;
      3'd2:    ch = 8'h58;
      3'd3:    ch = 8'h4D;
      default: ch = 8'h4C;
    endcase
    return ch;
  endfunction

  function automatic logic is_space(input byte_t b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_alnum(input byte_t b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic byte_t to_upper(input byte_t b);
    return (b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
  endfunction

  // A T G C, taken upper case
  function automatic logic is_nucleotide(input byte_t up);
    return (up == 8'h41) || (up == 8'h54) || (up == 8'h47) || (up == 8'h43);
  endfunction

  // U R Y K M S W B D H V N, taken upper case
  function automatic logic is_ambiguity(input byte_t up);
    return (up == 8'h55) || (up == 8'h52) || (up == 8'h59) || (up == 8'h4B) ||
           (up == 8'h4D) || (up == 8'h53) || (up == 8'h57) || (up == 8'h42) ||
           (up == 8'h44) || (up == 8'h48) || (up == 8'h56) || (up == 8'h4E);
  endfunction

endpackage

// ===== hdl/ffs_if.sv =====
// Channel interfaces of the sniffer: byte stream, result codes, register writes.
interface ffs_byte_if;
  import ffs_pkg::*;
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ffs_code_if;
  import ffs_pkg::*;
  logic  valid;
  logic  ready;
  code_t format_code;
  modport source (output valid, output format_code, input ready);
  modport sink (input valid, input format_code, output ready);
endinterface

interface ffs_cfg_if;
  import ffs_pkg::*;
  logic      valid;
  logic      ready;
  reg_idx_t  index;
  permille_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/file_format_sniffer.sv =====
// Top level of the file format sniffer: byte counters, ratio pipeline, result register.
//
//   channel  dir  payload                  handshake
//   feed     in   data_byte[8], last_byte  valid/ready
//   result   out  format_code[3]           valid/ready
//   cfg      in   index[2], data[10]       valid/ready, always ready
//
// One byte is taken per cycle while feed is ready; the counters update at the request itself.
// A last byte launches a snapshot through stage A (snapshot), stage B (products)
// and the result register (compares); one code per cycle can drain while result is ready.
// Synchronous active-high reset restores the registers' defaults and clears the counters.
// A stalled result holds the pipeline; feed drops ready only when all three stages are full.
`include "assert_macros.svh"

module file_format_sniffer #(
  parameter int unsigned WINDOW_BYTES = 1024
) (
  input logic clk,
  input logic rst,
  ffs_byte_if.sink   feed,
  ffs_code_if.source result,
  ffs_cfg_if.sink    cfg
);
  import ffs_pkg::*;

  localparam int unsigned CW = $clog2(WINDOW_BYTES + 1);
  localparam int unsigned PW = CW + PERMILLE_W;

  typedef logic [CW-1:0] cnt_t;
  typedef logic [PW-1:0] prod_t;

  typedef struct packed {
    cnt_t total;
    cnt_t nuc;
    cnt_t amb;
    cnt_t txt;
    logic xml_ok;
    logic gt;
    logic brace;
  } snap_t;

  typedef struct packed {
    logic  xml;
    logic  gt;
    logic  brace;
    prod_t txt_k;
    prod_t nuc_k;
    prod_t amb_k;
    prod_t dna_lim;
    prod_t prot_lim;
    prod_t ftxt_lim;
    prod_t txt_lim;
  } prod_set_t;

  // Configuration registers
  permille_t dna_permille, protein_permille, fasta_text_permille, text_permille;

  // Per-file state
  cnt_t byte_count, nucleotide_count, ambiguity_count, text_count;
  logic xml_prefix_ok, starts_with_gt, in_first_line, line_ends_brace;

  snap_t     nxt;
  logic      in_first_line_next;
  logic      feed_acc;
  byte_t     up;
  logic      take;

  logic      a_valid, b_valid;
  snap_t     a_snap;
  prod_set_t b_prod;
  logic      a_ready, b_ready;
  code_t     code_next;
  logic      out_valid;
  code_t     out_code;

  assign cfg.ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dna_permille        <= DNA_RESET;
      protein_permille    <= PROTEIN_RESET;
      fasta_text_permille <= FASTA_TXT_RESET;
      text_permille       <= TEXT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_DNA:       dna_permille        <= cfg.data;
        REG_PROTEIN:   protein_permille    <= cfg.data;
        REG_FASTA_TXT: fasta_text_permille <= cfg.data;
        REG_TEXT:      text_permille       <= cfg.data;
        default:       ;
      endcase
    end
  end

  // Pipeline flow control
  assign b_ready    = !out_valid || result.ready;
  assign a_ready    = !b_valid || b_ready;
  assign feed.ready = !a_valid || a_ready;
  assign feed_acc   = feed.valid && feed.ready;

  // Classify the incoming byte and form the updated counters
  always_comb begin
    up   = to_upper(feed.data_byte);
    take = byte_count < cnt_t'(WINDOW_BYTES);
    nxt.total = byte_count;
    nxt.nuc   = nucleotide_count;
    nxt.amb   = ambiguity_count;
    nxt.txt   = text_count;
    nxt.xml_ok = xml_prefix_ok;
    nxt.gt     = starts_with_gt;
    nxt.brace  = line_ends_brace;
    in_first_line_next = in_first_line;
    if (take) begin
      nxt.total = byte_count + cnt_t'(1);
      if (byte_count < cnt_t'(SIG_LEN) && up != xml_sig(byte_count[2:0])) begin
        nxt.xml_ok = 1'b0;
      end
      if (byte_count == '0) begin
        nxt.gt = (feed.data_byte == CH_GT);
      end
      if (is_alnum(feed.data_byte) || is_space(feed.data_byte)) begin
        nxt.txt = text_count + cnt_t'(1);
      end
      if (is_nucleotide(up)) begin
        nxt.nuc = nucleotide_count + cnt_t'(1);
      end
      if (is_ambiguity(up)) begin
        nxt.amb = ambiguity_count + cnt_t'(1);
      end
      if (in_first_line) begin
        if (feed.data_byte == CH_LF) begin
          in_first_line_next = 1'b0;
        end else if (!is_space(feed.data_byte)) begin
          nxt.brace = (feed.data_byte == CH_BRACE);
        end
      end
    end
  end

  // Advance the counters; clear them on reset and after the last byte of a file
  always_ff @(posedge clk) begin
    if (rst || (feed_acc && feed.last_byte)) begin
      byte_count       <= '0;
      nucleotide_count <= '0;
      ambiguity_count  <= '0;
      text_count       <= '0;
      xml_prefix_ok    <= 1'b1;
      starts_with_gt   <= 1'b0;
      in_first_line    <= 1'b1;
      line_ends_brace  <= 1'b0;
    end else if (feed_acc) begin
      byte_count       <= nxt.total;
      nucleotide_count <= nxt.nuc;
      ambiguity_count  <= nxt.amb;
      text_count       <= nxt.txt;
      xml_prefix_ok    <= nxt.xml_ok;
      starts_with_gt   <= nxt.gt;
      in_first_line    <= in_first_line_next;
      line_ends_brace  <= nxt.brace;
    end
  end

  // Stage A: hold the final counts of a file
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (feed.ready) begin
      a_valid <= feed_acc && feed.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (feed.ready && feed_acc && feed.last_byte) begin
      a_snap <= nxt;
    end
  end

  // Stage B: scale counts and thresholds
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && a_valid) begin
      b_prod.xml      <= (a_snap.total > cnt_t'(SIG_LEN)) && a_snap.xml_ok;
      b_prod.gt       <= a_snap.gt;
      b_prod.brace    <= a_snap.brace;
      b_prod.txt_k    <= prod_t'(a_snap.txt) * prod_t'(PERMILLE_SCALE);
      b_prod.nuc_k    <= prod_t'(a_snap.nuc) * prod_t'(PERMILLE_SCALE);
      b_prod.amb_k    <= prod_t'(a_snap.amb) * prod_t'(PERMILLE_SCALE);
      b_prod.dna_lim  <= prod_t'(dna_permille) * prod_t'(a_snap.total);
      b_prod.prot_lim <= prod_t'(protein_permille) * prod_t'(a_snap.total);
      b_prod.ftxt_lim <= prod_t'(fasta_text_permille) * prod_t'(a_snap.total);
      b_prod.txt_lim  <= prod_t'(text_permille) * prod_t'(a_snap.total);
    end
  end

  // Compare shares and pick the first matching format
  always_comb begin
    if (b_prod.xml) begin
      code_next = FMT_XML;
    end else if (b_prod.gt && (b_prod.txt_k > b_prod.ftxt_lim) &&
                 ((b_prod.nuc_k > b_prod.dna_lim) || (b_prod.amb_k > b_prod.prot_lim))) begin
      code_next = FMT_FASTA;
    end else if ((b_prod.txt_k > b_prod.txt_lim) && b_prod.brace) begin
      code_next = FMT_TEXT_ASN;
    end else if (b_prod.txt_k < b_prod.txt_lim) begin
      code_next = FMT_BINARY_ASN;
    end else begin
      code_next = FMT_UNKNOWN;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && b_valid) begin
      out_code <= code_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.format_code = out_code;

  // Checks
  `ASSERT_NEXT(a_last_clears, feed_acc && feed.last_byte, byte_count == '0 && a_valid, "last byte did not clear counters or load snapshot")
  `ASSERT_ALWAYS(a_window, byte_count <= cnt_t'(WINDOW_BYTES), "byte count past window")
  `ASSERT_ALWAYS(a_text_bound, text_count <= byte_count && nucleotide_count <= text_count && ambiguity_count <= text_count, "class counts exceed totals")
  `ASSERT_NEXT(a_stage_hold, a_valid && !a_ready, a_valid && $stable(a_snap), "stage A lost a held snapshot")
  `ASSERT_NEXT(a_b_hold, b_valid && !b_ready, b_valid, "stage B dropped a stalled result")

endmodule
